>>> hdl/tllik_pkg.sv
// shared types, widths, register codes and the arctangent table
// for the two-link leg inverse kinematics core; no dependencies
package tllik_pkg;

    localparam int CORDIC_STAGES = 16;

    localparam int TGT_W      = 16;
    localparam int CFG_LEN_W  = 13;
    localparam int CFG_OFF_W  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int SHOULDER_W = 15;
    localparam int LEG_W      = 17;
    localparam int WRIST_W    = 14;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_OFFSET = 2'd2;

    localparam logic [CFG_LEN_W-1:0] RESET_UPPER_LEN    = 13'd1778;
    localparam logic [CFG_LEN_W-1:0] RESET_LOWER_LEN    = 13'd1896;
    localparam logic [CFG_OFF_W-1:0] RESET_UPPER_OFFSET = 15'd4480;

    localparam int RSQ_W    = 2 * TGT_W;
    localparam int SQ_W     = 2 * CFG_LEN_W;
    localparam int AABB4_W  = 2 * SQ_W + 2;
    localparam int NM_W     = RSQ_W + 2;
    localparam int SQR_W    = 2 * NM_W - 4;
    localparam int DIFF_W   = SQR_W + 2;
    localparam int RAD_W    = 60;
    localparam int SQ_STEPS = RAD_W / 2;
    localparam int ROOT_W   = SQ_STEPS;

    localparam int VEC_W       = 36;
    localparam int MAG_W       = VEC_W - 1;
    localparam int NORM_W      = 31;
    localparam int NORM_STAGES = 7;
    localparam int ITER_W      = 34;
    localparam int Z_W         = 26;
    localparam int ANG_FRAC    = 10;
    localparam int ROUND_HALF  = 512;
    localparam int ANG_W       = 15;

    localparam int NUM_LANES = 3;
    localparam int LANE_LEAN = 0;
    localparam int LANE_UP   = 1;
    localparam int LANE_WR   = 2;

    localparam int QUARTER_TURN = 90 * 65536;
    localparam int LEAN_LIMIT   = 5760;
    localparam int ACOS_LIMIT   = 11520;

    localparam logic [SHOULDER_W-1:0] SHOULDER_ANGLE = 15'd5760;

    typedef struct packed {
        logic signed [TGT_W-1:0] target_x;
        logic signed [TGT_W-1:0] target_y;
    } t_target;

    typedef struct packed {
        logic        [SHOULDER_W-1:0] shoulder_angle;
        logic signed [LEG_W-1:0]      leg_angle;
        logic        [WRIST_W-1:0]    knee_angle;
        logic                         status;
    } t_result;

    typedef struct packed {
        logic [SQ_W-1:0]    aa;
        logic [SQ_W-1:0]    bb;
        logic [AABB4_W-1:0] aabb4;
    } t_cfg_prod;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } t_vec;

    typedef struct packed {
        t_vec                    lean;
        logic signed [VEC_W-1:0] up_x;
        logic signed [VEC_W-1:0] wr_x;
        logic                    bad;
    } t_sq_side;

    typedef struct packed {
        logic [RAD_W-1:0] rad_u;
        logic [RAD_W-1:0] rad_w;
        t_sq_side         side;
    } t_root_req;

    typedef struct packed {
        logic [ROOT_W-1:0] root_u;
        logic [ROOT_W-1:0] root_w;
        t_sq_side          side;
    } t_root_res;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        case (i)
            0:  atan_entry = Z_W'(2949120);
            1:  atan_entry = Z_W'(1740967);
            2:  atan_entry = Z_W'(919879);
            3:  atan_entry = Z_W'(466945);
            4:  atan_entry = Z_W'(234379);
            5:  atan_entry = Z_W'(117304);
            6:  atan_entry = Z_W'(58666);
            7:  atan_entry = Z_W'(29335);
            8:  atan_entry = Z_W'(14668);
            9:  atan_entry = Z_W'(7334);
            10: atan_entry = Z_W'(3667);
            11: atan_entry = Z_W'(1833);
            12: atan_entry = Z_W'(917);
            13: atan_entry = Z_W'(458);
            14: atan_entry = Z_W'(229);
            15: atan_entry = Z_W'(115);
            16: atan_entry = Z_W'(57);
            17: atan_entry = Z_W'(29);
            18: atan_entry = Z_W'(14);
            19: atan_entry = Z_W'(7);
            20: atan_entry = Z_W'(4);
            21: atan_entry = Z_W'(2);
            22: atan_entry = Z_W'(1);
            default: atan_entry = '0;
        endcase
    endfunction

endpackage

>>> hdl/tllik_front.sv
// front pipeline: squares, law-of-cosines terms and square-root radicands
// depends on tllik_pkg
module tllik_front import tllik_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_target   i_target,
    input  t_cfg_prod i_cfg,
    output logic      o_valid,
    output t_root_req o_req
);

    localparam int FRONT_STAGES = 6;

    logic r_valid [FRONT_STAGES];

    logic signed [TGT_W-1:0] r1_tx, r1_ty;

    logic [RSQ_W-1:0] r2_txx, r2_tyy;
    t_vec             r2_lean;
    logic             r2_neg;

    logic [RSQ_W-1:0] r3_rsq;
    t_vec             r3_lean;
    logic             r3_neg;

    logic signed [NM_W-1:0] r4_n, r4_m;
    logic [RAD_W-1:0]       r4_p1;
    t_vec                   r4_lean;
    logic                   r4_neg;

    logic [SQR_W-1:0]       r5_nn, r5_mm;
    logic [RAD_W-1:0]       r5_p1;
    logic signed [NM_W-1:0] r5_n, r5_m;
    t_vec                   r5_lean;
    logic                   r5_neg;

    t_root_req r6_req;

    logic signed [RSQ_W-1:0]  tx_sq, ty_sq;
    logic signed [VEC_W-1:0]  tx_ext, ty_ext;
    logic signed [NM_W-1:0]   n_n, n_m;
    logic [RAD_W-3:0]         p1_prod;
    logic signed [2*NM_W-1:0] n_sq, m_sq;
    logic signed [DIFF_W-1:0] du_s, dw_s;
    logic signed [VEC_W-1:0]  n_ext;
    t_root_req                n_req;

    assign tx_sq  = r1_tx * r1_tx;
    assign ty_sq  = r1_ty * r1_ty;
    assign tx_ext = VEC_W'(r1_tx);
    assign ty_ext = VEC_W'(r1_ty);

    assign n_n = $signed(NM_W'(i_cfg.aa)) + $signed(NM_W'(r3_rsq))
               - $signed(NM_W'(i_cfg.bb));
    assign n_m = $signed(NM_W'(i_cfg.aa)) + $signed(NM_W'(i_cfg.bb))
               - $signed(NM_W'(r3_rsq));
    assign p1_prod = i_cfg.aa * r3_rsq;

    assign n_sq = r4_n * r4_n;
    assign m_sq = r4_m * r4_m;

    assign du_s  = $signed(DIFF_W'(r5_p1)) - $signed(DIFF_W'(r5_nn));
    assign dw_s  = $signed(DIFF_W'(i_cfg.aabb4)) - $signed(DIFF_W'(r5_mm));
    assign n_ext = VEC_W'(r5_n);

    always_comb begin
        n_req.rad_u     = (du_s > 0) ? du_s[RAD_W-1:0] : '0;
        n_req.rad_w     = (dw_s > 0) ? dw_s[RAD_W-1:0] : '0;
        n_req.side.lean = r5_lean;
        n_req.side.up_x = r5_neg ? -n_ext : n_ext;
        n_req.side.wr_x = VEC_W'(r5_m);
        n_req.side.bad  = (du_s < 0) || (dw_s < 0) || (i_cfg.aa == '0) || (i_cfg.bb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < FRONT_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            // a zero vertical target produces no result
            r_valid[0] <= i_valid && (i_target.target_y != '0);
            for (int s = 1; s < FRONT_STAGES; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tx <= i_target.target_x;
            r1_ty <= i_target.target_y;

            r2_txx    <= $unsigned(tx_sq);
            r2_tyy    <= $unsigned(ty_sq);
            r2_lean.y <= (r1_ty < 0) ? -tx_ext : tx_ext;
            r2_lean.x <= (r1_ty < 0) ? -ty_ext : ty_ext;
            r2_neg    <= r1_ty < 0;

            r3_rsq  <= r2_txx + r2_tyy;
            r3_lean <= r2_lean;
            r3_neg  <= r2_neg;

            r4_n    <= n_n;
            r4_m    <= n_m;
            r4_p1   <= {p1_prod, 2'b00};
            r4_lean <= r3_lean;
            r4_neg  <= r3_neg;

            r5_nn   <= n_sq[SQR_W-1:0];
            r5_mm   <= m_sq[SQR_W-1:0];
            r5_p1   <= r4_p1;
            r5_n    <= r4_n;
            r5_m    <= r4_m;
            r5_lean <= r4_lean;
            r5_neg  <= r4_neg;

            r6_req <= n_req;
        end
    end

    assign o_valid = r_valid[FRONT_STAGES-1];
    assign o_req   = r6_req;

endmodule

>>> hdl/tllik_sqrt.sv
// pipelined integer square root, one result bit per stage, two radicands
// depends on tllik_pkg
module tllik_sqrt import tllik_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_root_req i_req,
    output logic      o_valid,
    output t_root_res o_res
);

    typedef struct packed {
        logic [RAD_W-1:0] v_u;
        logic [RAD_W-1:0] r_u;
        logic [RAD_W-1:0] v_w;
        logic [RAD_W-1:0] r_w;
        t_sq_side         side;
    } t_sq_stage;

    t_sq_stage r_stage [SQ_STEPS];
    logic      r_valid [SQ_STEPS];

    function automatic logic [2*RAD_W-1:0] sq_step(
        input logic [RAD_W-1:0] v,
        input logic [RAD_W-1:0] r,
        input logic [RAD_W-1:0] bitv
    );
        logic [RAD_W:0] t;
        t = {1'b0, r} + {1'b0, bitv};
        if ({1'b0, v} >= t) begin
            sq_step = {v - t[RAD_W-1:0], (r >> 1) + bitv};
        end else begin
            sq_step = {v, r >> 1};
        end
    endfunction

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
        localparam int BPOS = 2 * (SQ_STEPS - 1 - i);

        t_sq_stage        src, nxt;
        logic             src_valid;
        logic [RAD_W-1:0] bitv;

        if (i == 0) begin : g_head
            always_comb begin
                src.v_u   = i_req.rad_u;
                src.r_u   = '0;
                src.v_w   = i_req.rad_w;
                src.r_w   = '0;
                src.side  = i_req.side;
                src_valid = i_valid;
            end
        end else begin : g_body
            always_comb begin
                src       = r_stage[i-1];
                src_valid = r_valid[i-1];
            end
        end

        assign bitv = RAD_W'(1) << BPOS;

        always_comb begin
            nxt = src;
            {nxt.v_u, nxt.r_u} = sq_step(src.v_u, src.r_u, bitv);
            {nxt.v_w, nxt.r_w} = sq_step(src.v_w, src.r_w, bitv);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stage[i] <= nxt;
            end
        end
    end

    assign o_valid      = r_valid[SQ_STEPS-1];
    assign o_res.root_u = r_stage[SQ_STEPS-1].r_u[ROOT_W-1:0];
    assign o_res.root_w = r_stage[SQ_STEPS-1].r_w[ROOT_W-1:0];
    assign o_res.side   = r_stage[SQ_STEPS-1].side;

endmodule

>>> hdl/tllik_cordic.sv
// pipelined vectoring cordic atan2 over three lanes: magnitude, normalizing
// shifts, quadrant fold, then one rotation per stage; depends on tllik_pkg
module tllik_cordic import tllik_pkg::*; (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic                              i_bad,
    input  t_vec [NUM_LANES-1:0]              i_vecs,
    output logic                              o_valid,
    output logic                              o_bad,
    output logic [NUM_LANES-1:0][Z_W-1:0]     o_angles
);

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [MAG_W-1:0]        mag;
    } t_nrm;

    typedef struct packed {
        logic signed [ITER_W-1:0] x;
        logic signed [ITER_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic                     zero;
    } t_rot;

    t_nrm r_nrm  [NORM_STAGES][NUM_LANES];
    logic r_nv   [NORM_STAGES];
    logic r_nbad [NORM_STAGES];

    t_rot r_rot  [CORDIC_STAGES+1][NUM_LANES];
    logic r_rv   [CORDIC_STAGES+1];
    logic r_rbad [CORDIC_STAGES+1];

    for (genvar j = 0; j < NORM_STAGES; j++) begin : g_nrm
        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            t_nrm nxt;

            if (j == 0) begin : g_max
                logic [VEC_W-1:0] ax, ay, amax;
                assign ax   = (i_vecs[l].x < 0) ? $unsigned(-i_vecs[l].x)
                                                : $unsigned(i_vecs[l].x);
                assign ay   = (i_vecs[l].y < 0) ? $unsigned(-i_vecs[l].y)
                                                : $unsigned(i_vecs[l].y);
                assign amax = (ax > ay) ? ax : ay;
                always_comb begin
                    nxt.x   = i_vecs[l].x;
                    nxt.y   = i_vecs[l].y;
                    nxt.mag = amax[MAG_W-1:0];
                end
            end else if (j == 1) begin : g_down
                always_comb begin
                    logic [2:0] sh;
                    sh = '0;
                    for (int p = NORM_W; p < MAG_W; p++) begin
                        if (r_nrm[0][l].mag[p]) begin
                            sh = 3'(p - NORM_W + 1);
                        end
                    end
                    nxt.x   = r_nrm[0][l].x >>> sh;
                    nxt.y   = r_nrm[0][l].y >>> sh;
                    nxt.mag = r_nrm[0][l].mag >> sh;
                end
            end else begin : g_up
                localparam int SH = 1 << (NORM_STAGES - 1 - j);
                always_comb begin
                    nxt = r_nrm[j-1][l];
                    if ((r_nrm[j-1][l].mag >> (NORM_W - SH)) == '0) begin
                        nxt.x   = r_nrm[j-1][l].x <<< SH;
                        nxt.y   = r_nrm[j-1][l].y <<< SH;
                        nxt.mag = r_nrm[j-1][l].mag << SH;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nrm[j][l] <= nxt;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[j] <= 1'b0;
            end else if (i_en) begin
                r_nv[j] <= (j == 0) ? i_valid : r_nv[(j == 0) ? 0 : j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nbad[j] <= (j == 0) ? i_bad : r_nbad[(j == 0) ? 0 : j-1];
            end
        end
    end

    // quadrant fold into the right half plane
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_fold
        t_nrm                     src;
        logic signed [ITER_W-1:0] xs, ys;
        t_rot                     nxt;

        assign src = r_nrm[NORM_STAGES-1][l];
        assign xs  = ITER_W'(src.x);
        assign ys  = ITER_W'(src.y);

        always_comb begin
            nxt.x    = xs;
            nxt.y    = ys;
            nxt.z    = '0;
            nxt.zero = (src.mag == '0);
            if (xs < 0) begin
                if (ys >= 0) begin
                    nxt.x = ys;
                    nxt.y = -xs;
                    nxt.z = Z_W'(QUARTER_TURN);
                end else begin
                    nxt.x = -ys;
                    nxt.y = xs;
                    nxt.z = -Z_W'(QUARTER_TURN);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rot[0][l] <= nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else if (i_en) begin
            r_rv[0] <= r_nv[NORM_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rbad[0] <= r_nbad[NORM_STAGES-1];
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            t_rot                     src, nxt;
            logic signed [ITER_W-1:0] dx, dy;

            assign src = r_rot[i][l];
            assign dx  = src.y >>> i;
            assign dy  = src.x >>> i;

            always_comb begin
                nxt = src;
                if (src.y >= 0) begin
                    nxt.x = src.x + dx;
                    nxt.y = src.y - dy;
                    nxt.z = src.z + atan_entry(i);
                end else begin
                    nxt.x = src.x - dx;
                    nxt.y = src.y + dy;
                    nxt.z = src.z - atan_entry(i);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rot[i+1][l] <= nxt;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[i+1] <= 1'b0;
            end else if (i_en) begin
                r_rv[i+1] <= r_rv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rbad[i+1] <= r_rbad[i];
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
        assign o_angles[l] = r_rot[CORDIC_STAGES][l].zero ? '0
                                                          : r_rot[CORDIC_STAGES][l].z;
    end

    assign o_valid = r_rv[CORDIC_STAGES];
    assign o_bad   = r_rbad[CORDIC_STAGES];

endmodule

>>> hdl/two_link_leg_inverse_kinematics_core.sv
// throughput: one target per cycle while o_stall is low; the 30-stage square root
// and 24-stage cordic pipelines are the deepest, and every stage takes a new beat
// each cycle that the pipeline is not stalled
// a held result stalls the whole pipeline until it is taken
// reset: synchronous active low, clears all valid bits and restores link defaults
module two_link_leg_inverse_kinematics_core import tllik_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_target               i_target,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [Z_W:0] LEAN_HI = (Z_W+1)'(LEAN_LIMIT);
    localparam logic signed [Z_W:0] LEAN_LO = -LEAN_HI;
    localparam logic signed [Z_W:0] ACOS_HI = (Z_W+1)'(ACOS_LIMIT);
    localparam logic signed [Z_W:0] ACOS_LO = '0;

    logic [CFG_LEN_W-1:0] r_upper_len, r_lower_len;
    logic [CFG_OFF_W-1:0] r_offset;
    t_cfg_prod            r_cfg;
    logic [2*SQ_W-1:0]    aabb;

    logic en;

    logic      front_valid;
    t_root_req front_req;
    logic      sq_valid;
    t_root_res sq_res;

    t_vec [NUM_LANES-1:0]          vecs;
    logic                          cd_valid, cd_bad;
    logic [NUM_LANES-1:0][Z_W-1:0] angles;

    logic signed [Z_W:0] rnd [NUM_LANES];
    logic signed [Z_W:0] clp [NUM_LANES];

    logic                    r_ang_valid, r_ang_bad;
    logic signed [ANG_W-1:0] r_ang [NUM_LANES];

    logic signed [LEG_W:0] leg;
    logic                  r_out_valid;
    t_result               r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_len <= RESET_UPPER_LEN;
            r_lower_len <= RESET_LOWER_LEN;
            r_offset    <= RESET_UPPER_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_UPPER_LEN:    r_upper_len <= i_cfg_data[CFG_LEN_W-1:0];
                REG_LOWER_LEN:    r_lower_len <= i_cfg_data[CFG_LEN_W-1:0];
                REG_UPPER_OFFSET: r_offset    <= i_cfg_data[CFG_OFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign aabb = r_cfg.aa * r_cfg.bb;

    always_ff @(posedge i_clk) begin
        r_cfg.aa    <= r_upper_len * r_upper_len;
        r_cfg.bb    <= r_lower_len * r_lower_len;
        r_cfg.aabb4 <= {aabb, 2'b00};
    end

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    tllik_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_target (i_target),
        .i_cfg    (r_cfg),
        .o_valid  (front_valid),
        .o_req    (front_req)
    );

    tllik_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_req   (front_req),
        .o_valid (sq_valid),
        .o_res   (sq_res)
    );

    always_comb begin
        vecs[LANE_LEAN]   = sq_res.side.lean;
        vecs[LANE_UP].x   = sq_res.side.up_x;
        vecs[LANE_UP].y   = VEC_W'(sq_res.root_u);
        vecs[LANE_WR].x   = sq_res.side.wr_x;
        vecs[LANE_WR].y   = VEC_W'(sq_res.root_w);
    end

    tllik_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (sq_valid),
        .i_bad    (sq_res.side.bad),
        .i_vecs   (vecs),
        .o_valid  (cd_valid),
        .o_bad    (cd_bad),
        .o_angles (angles)
    );

    // round to 1/64 degree and clamp
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_rnd
        logic signed [Z_W:0] sum;
        assign sum    = (Z_W+1)'($signed(angles[l])) + (Z_W+1)'(ROUND_HALF);
        assign rnd[l] = sum >>> ANG_FRAC;
        if (l == LANE_LEAN) begin : g_lean
            assign clp[l] = (rnd[l] < LEAN_LO) ? LEAN_LO :
                            (rnd[l] > LEAN_HI) ? LEAN_HI : rnd[l];
        end else begin : g_acos
            assign clp[l] = (rnd[l] < ACOS_LO) ? ACOS_LO :
                            (rnd[l] > ACOS_HI) ? ACOS_HI : rnd[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_ang_valid <= cd_valid;
            r_out_valid <= r_ang_valid;
        end
    end

    assign leg = (LEG_W+1)'(r_ang[LANE_LEAN]) + (LEG_W+1)'(r_ang[LANE_UP])
               + $signed((LEG_W+1)'(r_offset));

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_ang[l] <= clp[l][ANG_W-1:0];
            end
            r_ang_bad <= cd_bad;

            r_result.shoulder_angle <= SHOULDER_ANGLE;
            r_result.leg_angle      <= leg[LEG_W-1:0];
            r_result.knee_angle     <= r_ang[LANE_WR][WRIST_W-1:0];
            r_result.status         <= r_ang_bad;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    a_shoulder_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.shoulder_angle == SHOULDER_ANGLE)
        else $error("shoulder angle is not the fixed value");

    a_knee_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.knee_angle <= WRIST_W'(ACOS_LIMIT))
        else $error("knee angle beyond half turn");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

endmodule

>>> sim/tb_two_link_leg_inverse_kinematics_core.sv
// self-checking bench for two_link_leg_inverse_kinematics_core: targets from a queue,
// results checked against a bit-exact cordic and square-root predictor
// depends on hdl/tllik_pkg.sv and hdl/two_link_leg_inverse_kinematics_core.sv and its submodules
module tb_two_link_leg_inverse_kinematics_core;
    import tllik_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES  = 80;
    localparam int NO_IDLE_FIRST = 700;
    localparam int NO_IDLE_LAST  = 1300;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_target               i_target = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_UPPER_LEN;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_target pending_targets[$];
    t_result expected_angles[$];
    longint  upper_len = RESET_UPPER_LEN;
    longint  lower_len = RESET_LOWER_LEN;
    longint  angle_offset = RESET_UPPER_OFFSET;
    int      errors = 0;
    int      cyc = 0;
    int      accepted = 0;
    int      hold_left = 0;
    bit      hold_done = 0;

    two_link_leg_inverse_kinematics_core u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint floor_root(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
        longint xa = xv, ya = yv, z = 0, m, t, dx, dy;
        m = labs(xa) > labs(ya) ? labs(xa) : labs(ya);
        if (m == 0) return 0;
        while (m < (64'sd1 <<< 30)) begin
            xa *= 2; ya *= 2; m *= 2;
        end
        while (m >= (64'sd1 <<< 31)) begin
            xa = xa >>> 1; ya = ya >>> 1; m = m >>> 1;
        end
        if (xa < 0) begin
            t = xa;
            if (ya >= 0) begin
                xa = ya; ya = -t; z = 90 * 65536;
            end else begin
                xa = -ya; ya = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (ya >= 0) begin
                xa += dx; ya -= dy; z += longint'(atan_entry(i));
            end else begin
                xa -= dx; ya += dy; z -= longint'(atan_entry(i));
            end
        end
        return z;
    endfunction

    function automatic longint to_64ths(longint ang, longint lo, longint hi);
        longint r = (ang + 512) >>> 10;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    function automatic void predict_angles(t_target tg);
        longint tx = tg.target_x, ty = tg.target_y;
        longint a = upper_len, b = lower_len;
        longint sg, r2, n, m, du, dw, su, sw, lean, up, wr;
        t_result res;
        if (ty == 0) return;
        sg = ty > 0 ? 1 : -1;
        r2 = tx * tx + ty * ty;
        lean = to_64ths(vector_angle(sg * tx, labs(ty)), -5760, 5760);
        n = a * a + r2 - b * b;
        du = 4 * a * a * r2 - n * n;
        su = du > 0 ? floor_root(du) : 0;
        up = to_64ths(vector_angle(su, sg * n), 0, 11520);
        m = a * a + b * b - r2;
        dw = 4 * a * a * b * b - m * m;
        sw = dw > 0 ? floor_root(dw) : 0;
        wr = to_64ths(vector_angle(sw, m), 0, 11520);
        res.shoulder_angle = 15'd5760;
        res.leg_angle      = LEG_W'(up + angle_offset + lean);
        res.knee_angle     = WRIST_W'(wr);
        res.status         = (du < 0 || dw < 0 || a == 0 || b == 0);
        expected_angles.push_back(res);
    endfunction

    // driver
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict_angles(i_target);
                accepted <= accepted + 1;
            end
            if (pending_targets.size() != 0 &&
                    ((cyc > NO_IDLE_FIRST && cyc < NO_IDLE_LAST) ||
                     $urandom_range(99) >= 9)) begin
                i_target <= pending_targets.pop_front();
                i_valid  <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!hold_done && accepted >= 120) begin
            hold_done <= 1;
            hold_left <= 300;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        i_stall <= (hold_left > 1) ||
                   (!(cyc > NO_IDLE_FIRST && cyc < NO_IDLE_LAST) && $urandom_range(99) < 9);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_angles.size() == 0) begin
                $error("unexpected result beat %h", o_result);
                errors++;
            end else begin
                exp_r = expected_angles.pop_front();
                if (o_result.shoulder_angle !== exp_r.shoulder_angle) begin
                    $error("shoulder_angle exp %0d got %0d",
                           exp_r.shoulder_angle, o_result.shoulder_angle);
                    errors++;
                end
                if (o_result.leg_angle !== exp_r.leg_angle) begin
                    $error("leg_angle exp %0d got %0d",
                           exp_r.leg_angle, o_result.leg_angle);
                    errors++;
                end
                if (o_result.knee_angle !== exp_r.knee_angle) begin
                    $error("knee_angle exp %0d got %0d",
                           exp_r.knee_angle, o_result.knee_angle);
                    errors++;
                end
                if (o_result.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_result.status);
                    errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_targets.size() != 0 || i_valid || expected_angles.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_UPPER_LEN:    upper_len = data & 15'h1FFF;
            REG_LOWER_LEN:    lower_len = data & 15'h1FFF;
            REG_UPPER_OFFSET: angle_offset = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic push_target(int x, int y);
        t_target tg;
        tg.target_x = TGT_W'(x);
        tg.target_y = TGT_W'(y);
        pending_targets.push_back(tg);
    endtask

    task automatic push_random(int count);
        int span;
        span = int'(upper_len + lower_len + (upper_len + lower_len) / 4 + 16);
        if (span > 32767) span = 32767;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 80)
                push_target($urandom_range(2 * span) - span, $urandom_range(2 * span) - span);
            else
                push_target($urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        push_target(32767, 32767);
        push_target(-32768, -32768);
        push_target(-32768, 32767);
        push_target(32767, -32768);
        push_target(0, 1);
        push_target(0, -1);
        push_target(1234, 0);
        push_target(0, 2500);
        push_target(1000, 2000);
        push_target(-1500, 2200);
        push_target(0, 3674);
        push_target(0, 118);
        push_target(0, 117);
        push_target(0, 4000);
        push_target(500, -3000);
        push_random(150);
        wait_idle();
        write_reg(REG_UPPER_LEN, 15'd8191);
        write_reg(REG_LOWER_LEN, 15'd1);
        write_reg(REG_UPPER_OFFSET, 15'd23040);
        push_target(0, 8191);
        push_target(0, 8190);
        push_random(90);
        wait_idle();
        write_reg(REG_UPPER_LEN, 15'd1);
        write_reg(REG_LOWER_LEN, 15'd8191);
        write_reg(REG_UPPER_OFFSET, 15'd0);
        push_random(90);
        wait_idle();
        write_reg(REG_UPPER_LEN, 15'd0);
        write_reg(REG_LOWER_LEN, 15'h7FFF);
        write_reg(REG_UNUSED, 15'h1234);
        push_target(100, 200);
        push_random(40);
        wait_idle();
        write_reg(REG_UPPER_LEN, 15'h6000 | 15'd900);
        write_reg(REG_LOWER_LEN, 15'd0);
        write_reg(REG_UPPER_OFFSET, 15'h5555);
        push_random(40);
        wait_idle();
        write_reg(REG_UPPER_LEN, 15'd3000);
        write_reg(REG_LOWER_LEN, 15'd2500);
        write_reg(REG_UPPER_OFFSET, 15'd10000);
        push_random(100);
        wait_idle();
        if (errors == 0)
            $display("two_link_leg_inverse_kinematics_core test passed");
        else
            $display("two_link_leg_inverse_kinematics_core test failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("two_link_leg_inverse_kinematics_core test failed");
        $finish;
    end
endmodule
